[hw/rtl/adc_frame_deframer_crc_check_assert.svh]
// assertion macros shared by the deframer modules
// each expects clk and rst_n in scope
`ifndef ADC_FRAME_DEFRAMER_CRC_CHECK_ASSERT_SVH
`define ADC_FRAME_DEFRAMER_CRC_CHECK_ASSERT_SVH

// condition must never hold
`define AFD_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// consequent in the same cycle
`define AFD_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the following cycle
`define AFD_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/afd_pkg.sv]
`default_nettype none

package afd_pkg;

    // frame geometry
    localparam int FRAME_WORDS = 18;
    localparam int CHANNELS    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int STORE_DEPTH = 16;

    localparam int WORD_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 4;
    localparam int VOLT_W   = 17;
    localparam int POS_W    = 5;
    localparam int ADDR_W   = 4;
    localparam int ENTRY_W  = SAMPLE_W + 1;

    // configuration register indexes
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [REG_IDX_W-1:0] REG_HEADER  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TRAILER = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_POLY    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ORDER   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS  = 3'd4;

    // register reset values
    localparam logic [31:0] HEADER_RST  = 32'h0000_0000;
    localparam logic [31:0] TRAILER_RST = 32'h0000_0000;
    localparam logic [7:0]  POLY_RST    = 8'h9B;
    localparam logic [63:0] ORDER_RST   = 64'hFEDC_BA98_7654_3210;
    localparam logic [15:0] RADIUS_RST  = 16'd10000;

    // frame store write port
    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] data;
    } mem_wr_t;

    // frame store read port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } mem_rd_t;

    // no-init crc8, msb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] b, input logic [7:0] poly);
        logic [7:0] c;
        c = b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ poly;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/afd_if.sv]
`default_nettype none

// stream word channel
interface afd_word_if;
    import afd_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

// per-channel result channel
interface afd_result_if;
    import afd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CHAN_W-1:0]        channel;
    logic signed [VOLT_W-1:0] voltage;
    logic                     crc_ok;
    logic                     last;

    modport source (output valid, output channel, output voltage, output crc_ok,
                    output last, input ready);
    modport sink   (input valid, input channel, input voltage, input crc_ok,
                    input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/afd_frame_mem.sv]
`default_nettype none

module afd_frame_mem
    import afd_pkg::*;
(
    input  wire                 clk,
    input  mem_wr_t             wr,
    input  mem_rd_t             rd,
    output logic [ENTRY_W-1:0]  rd_data
);

    // {sample, crc ok} per data slot
    logic [ENTRY_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
            rd_data <= mem[rd.addr];
    end

endmodule

`default_nettype wire

[hw/rtl/afd_ingest.sv]
`default_nettype none

module afd_ingest
    import afd_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    afd_word_if.sink         stream,
    input  wire [31:0]       header_word,
    input  wire [31:0]       trailer_word,
    input  wire [7:0]        crc_polynomial,
    input  wire              busy,
    output mem_wr_t          mem_wr,
    output logic             start
);

    `include "adc_frame_deframer_crc_check_assert.svh"

    localparam logic [POS_W-1:0] TRAILER_POS = POS_W'(FRAME_WORDS - 1);
    localparam logic [POS_W-1:0] DEPTH_POS   = POS_W'(STORE_DEPTH);

    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             accept;
    logic [POS_W-1:0] slot;
    logic [SAMPLE_W-1:0] sample;
    logic             crc_match;

    assign stream.ready = !busy;
    assign accept       = stream.valid && !busy;

    assign sample    = stream.word[31:16];
    assign slot      = pos_reg - POS_W'(1);
    assign crc_match = (crc8_byte(sample[15:8], crc_polynomial) == stream.word[15:8]) &&
                       (crc8_byte(sample[7:0], crc_polynomial) == stream.word[7:0]);

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        mem_wr.en     = 1'b0;
        mem_wr.addr   = slot[ADDR_W-1:0];
        mem_wr.data   = {sample, crc_match};
        start         = 1'b0;
        if (accept)
        begin
            if (!in_frame_reg)
            begin
                // hunting
                if (stream.word == header_word)
                begin
                    in_frame_next = 1'b1;
                    pos_next      = POS_W'(1);
                end
            end
            else if (pos_reg < TRAILER_POS)
            begin
                mem_wr.en = (slot < DEPTH_POS);
                pos_next  = pos_reg + POS_W'(1);
            end
            else
            begin
                // trailer slot: emit on match, back to hunting either way
                start         = (stream.word == trailer_word);
                in_frame_next = 1'b0;
                pos_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
        end
    end

    `AFD_IMPLIES(a_wr_in_frame, mem_wr.en, in_frame_reg && accept, "store write outside a frame")
    `AFD_NEXT(a_start_blocks, start, !stream.ready, "input not held off after trailer")

endmodule

`default_nettype wire

[hw/rtl/afd_emit.sv]
`default_nettype none

module afd_emit
    import afd_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire [63:0]           channel_order,
    input  wire [15:0]           range_radius,
    input  wire [ENTRY_W-1:0]    rd_data,
    output mem_rd_t              mem_rd,
    output logic                 busy,
    afd_result_if.source         result
);

    `include "adc_frame_deframer_crc_check_assert.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam int PROD_W = 2 * VOLT_W - 1;
    localparam logic [CHAN_W-1:0]        LAST_CHAN = CHAN_W'(CHANNELS - 1);
    localparam logic signed [PROD_W-1:0] VMAX      = PROD_W'(65535);
    localparam logic signed [PROD_W-1:0] VMIN      = -PROD_W'(65535);

    logic [1:0]               state_reg, state_next;
    logic [CHAN_W-1:0]        chan_reg, chan_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     ok_reg, ok_next;

    logic                     out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]        out_chan_reg, out_chan_next;
    logic signed [VOLT_W-1:0] out_volt_reg, out_volt_next;
    logic                     out_ok_reg, out_ok_next;
    logic                     out_last_reg, out_last_next;

    logic signed [VOLT_W-1:0] sample_s;
    logic signed [VOLT_W-1:0] radius_s;
    logic signed [PROD_W-1:0] scaled;
    logic signed [VOLT_W-1:0] volt;
    logic                     out_free;

    assign sample_s = {rd_data[ENTRY_W-1], rd_data[ENTRY_W-1:1]};
    assign radius_s = {1'b0, range_radius};
    assign scaled   = prod_reg >>> (SAMPLE_BITS - 1);

    // floor division by the shift, then clamp; range_radius when the crc failed
    always_comb
    begin
        if (!ok_reg)
            volt = {1'b0, range_radius};
        else if (scaled > VMAX)
            volt = VMAX[VOLT_W-1:0];
        else if (scaled < VMIN)
            volt = VMIN[VOLT_W-1:0];
        else
            volt = scaled[VOLT_W-1:0];
    end

    assign out_free = !out_valid_reg || result.ready;
    assign busy     = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        prod_next      = prod_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_chan_next  = out_chan_reg;
        out_volt_next  = out_volt_reg;
        out_ok_next    = out_ok_reg;
        out_last_next  = out_last_reg;
        mem_rd.en      = 1'b0;
        mem_rd.addr    = channel_order[{chan_reg, 2'b00} +: ADDR_W];
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    chan_next  = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                mem_rd.en  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(sample_s) * PROD_W'(radius_s);
                ok_next    = rd_data[0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_chan_next  = chan_reg;
                    out_volt_next  = volt;
                    out_ok_next    = ok_reg;
                    out_last_next  = (chan_reg == LAST_CHAN);
                    if (chan_reg == LAST_CHAN)
                        state_next = ST_IDLE;
                    else
                    begin
                        chan_next  = chan_reg + CHAN_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        ok_reg       <= ok_next;
        out_chan_reg <= out_chan_next;
        out_volt_reg <= out_volt_next;
        out_ok_reg   <= out_ok_next;
        out_last_reg <= out_last_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.channel = out_chan_reg;
    assign result.voltage = out_volt_reg;
    assign result.crc_ok  = out_ok_reg;
    assign result.last    = out_last_reg;

    `AFD_NEVER(a_start_busy, start && busy, "frame start while still emitting")
    `AFD_IMPLIES(a_mul_after_read, state_reg == ST_MUL, $past(mem_rd.en), "multiply without read")
    `AFD_IMPLIES(a_last_chan, result.valid && result.last, result.channel == LAST_CHAN,
        "last flag on wrong channel")

endmodule

`default_nettype wire

[hw/rtl/adc_frame_deframer_crc_check.sv]
// adc frame deframer with per-byte crc8 check. stream words come in on the stream
// channel; the block hunts for header_word, stores the data words of the frame
// ({sample, crc ok} per slot) in a 16-entry frame memory, and when the trailer
// slot matches trailer_word it emits one result per channel in channel_order,
// scaled as floor(sample * range_radius / 2^15) millivolts, or range_radius when
// a crc byte failed. rate: while collecting, one word is taken every cycle. after
// a matching trailer the input is held off while the results are produced by a
// sequencer on the single read port of the frame memory: each result is read,
// multiplied, then scaled and loaded into the output register, and the sequencer
// waits whenever the result side stalls. the last result may still wait in the
// output register while the next frame is taken in. configuration is written
// through cfg_wr_en, cfg_index, cfg_data; the user writes it only while idle, the block does not check.
`default_nettype none

module adc_frame_deframer_crc_check
    import afd_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_wr_en,
    input  wire [REG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data,
    afd_word_if.sink              stream,
    afd_result_if.source          result
);

    `include "adc_frame_deframer_crc_check_assert.svh"

    // configuration registers
    logic [31:0] header_reg;
    logic [31:0] trailer_reg;
    logic [7:0]  poly_reg;
    logic [63:0] order_reg;
    logic [15:0] radius_reg;

    // between ingest, frame memory and emitter
    mem_wr_t             mem_wr;
    mem_rd_t             mem_rd;
    logic [ENTRY_W-1:0]  rd_data;
    logic                start;
    logic                busy;

    // register writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= HEADER_RST;
            trailer_reg <= TRAILER_RST;
            poly_reg    <= POLY_RST;
            order_reg   <= ORDER_RST;
            radius_reg  <= RADIUS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_HEADER:  header_reg  <= cfg_data[31:0];
                REG_TRAILER: trailer_reg <= cfg_data[31:0];
                REG_POLY:    poly_reg    <= cfg_data[7:0];
                REG_ORDER:   order_reg   <= cfg_data;
                REG_RADIUS:  radius_reg  <= cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    // header hunt, crc check and store writes
    afd_ingest u_ingest (
        .clk            (clk),
        .rst_n          (rst_n),
        .stream         (stream),
        .header_word    (header_reg),
        .trailer_word   (trailer_reg),
        .crc_polynomial (poly_reg),
        .busy           (busy),
        .mem_wr         (mem_wr),
        .start          (start)
    );

    // frame memory, one write and one registered read port
    afd_frame_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (rd_data)
    );

    // per-channel read, scale and output register
    afd_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .channel_order (order_reg),
        .range_radius  (radius_reg),
        .rd_data       (rd_data),
        .mem_rd        (mem_rd),
        .busy          (busy),
        .result        (result)
    );

    // the input is held off while reading, so writes and reads never collide
    `AFD_NEVER(a_no_rw_overlap, mem_wr.en && mem_rd.en, "frame memory write during emit read")

endmodule

`default_nettype wire

[tb/adc_frame_deframer_crc_check_tb.sv]
module adc_frame_deframer_crc_check_tb;
    import afd_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 11;
    // settle time after the result sequencer and the store write
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_SHOWN     = 10;

    // one per-channel result as it leaves the block
    typedef struct packed {
        logic [CHAN_W-1:0]        channel;
        logic signed [VOLT_W-1:0] voltage;
        logic                     crc_ok;
        logic                     last;
    } channel_result_t;

    // shapes of frame the stimulus builds
    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_TRAILER,
        FRAME_HEADER_INSIDE
    } frame_kind_e;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    afd_word_if   stream_ch();
    afd_result_if result_ch();

    adc_frame_deframer_crc_check DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (stream_ch),
        .result    (result_ch)
    );

    // shadow of the register file, updated at the edge the block takes a write
    logic [31:0] header_val;
    logic [31:0] trailer_val;
    logic [7:0]  poly_val;
    logic [63:0] order_val;
    logic [15:0] radius_val;

    // deframer state as the predictor sees it
    logic        collecting;
    int unsigned frame_pos;
    logic [15:0] slot_sample [STORE_DEPTH];
    logic        slot_ok     [STORE_DEPTH];

    // words waiting to be offered, and channel results still owed by the block
    logic [WORD_W-1:0] word_backlog[$];
    channel_result_t   pending_results[$];

    // idling knobs, percent of cycles
    int send_idle_pct;
    int recv_stall_pct;

    logic word_taken;
    int   cycle_count;
    int   requests_taken;
    int   frames_closed;
    int   frames_dropped;
    int   results_checked;
    int   error_count;

    // no-init crc8, shifted out msb first
    function automatic logic [7:0] byte_crc(input logic [7:0] d, input logic [7:0] poly);
        logic [7:0] r;
        logic       msb;
        r = d;
        repeat (8)
        begin
            msb = r[7];
            r   = r << 1;
            if (msb)
                r = r ^ poly;
        end
        return r;
    endfunction

    // floor(sample * radius / 2^15), clipped to -65535..65535 in the 17-bit signed result
    function automatic logic signed [VOLT_W-1:0] to_millivolts(input logic [15:0] raw,
                                                               input logic [15:0] radius);
        longint prod;
        longint q;
        prod = longint'($signed(raw)) * longint'(radius);
        q    = prod >>> (SAMPLE_BITS - 1);
        if (q > 65535)
            q = 65535;
        if (q < -65535)
            q = -65535;
        return q[VOLT_W-1:0];
    endfunction

    // advance the predicted deframer by one stream request
    function automatic void absorb_stream_word(input logic [WORD_W-1:0] w);
        channel_result_t r;
        logic [3:0]      slot;
        requests_taken++;
        // hunting: only the header value opens a frame
        if (!collecting)
        begin
            if (w == header_val)
            begin
                collecting = 1'b1;
                frame_pos  = 1;
            end
            return;
        end
        // data slot: crc checked with the polynomial in force right now
        if (frame_pos < FRAME_WORDS - 1)
        begin
            if (frame_pos - 1 < STORE_DEPTH)
            begin
                slot_sample[frame_pos - 1] = w[31:16];
                slot_ok[frame_pos - 1]     = byte_crc(w[31:24], poly_val) == w[15:8] &&
                                             byte_crc(w[23:16], poly_val) == w[7:0];
            end
            frame_pos++;
            return;
        end
        // trailer slot: a match releases one result per channel
        if (w == trailer_val)
        begin
            for (int j = 0; j < CHANNELS; j++)
            begin
                slot      = order_val[4*j +: 4];
                r.channel = CHAN_W'(j);
                r.crc_ok  = slot_ok[slot];
                r.voltage = slot_ok[slot] ? to_millivolts(slot_sample[slot], radius_val)
                                          : $signed({1'b0, radius_val});
                r.last    = (j == CHANNELS - 1);
                pending_results = {pending_results, r};
            end
            frames_closed++;
        end
        else
        begin
            frames_dropped++;
        end
        collecting = 1'b0;
        frame_pos  = 0;
    endfunction

    function automatic void note_fault(input string what, input channel_result_t want,
                                       input channel_result_t got);
        error_count++;
        if (error_count <= MAX_SHOWN)
        begin
            $display("result %0d %s: expected ch=%0d mv=%0d ok=%0b last=%0b",
                     results_checked, what, want.channel, want.voltage, want.crc_ok,
                     want.last);
            $display("    got ch=%0d mv=%0d ok=%0b last=%0b",
                     got.channel, got.voltage, got.crc_ok, got.last);
        end
    endfunction

    // pick a sample, leaning on the range extremes
    function automatic logic [15:0] random_sample();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // data word with crc bytes under the current polynomial, optionally damaged
    function automatic logic [WORD_W-1:0] sample_word(input logic [15:0] s, input logic good);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = byte_crc(s[15:8], poly_val);
        lo = byte_crc(s[7:0], poly_val);
        if (!good)
        begin
            case ($urandom_range(2))
                0: hi = hi ^ 8'($urandom_range(255, 1));
                1: lo = lo ^ 8'($urandom_range(255, 1));
                default:
                begin
                    hi = 8'($urandom);
                    lo = 8'($urandom);
                end
            endcase
        end
        return {s, hi, lo};
    endfunction

    // stray words that the hunt skips over
    task automatic queue_noise(input int count);
        logic [WORD_W-1:0] w;
        for (int k = 0; k < count; k++)
        begin
            do
                w = $urandom;
            while (w == header_val);
            word_backlog = {word_backlog, w};
        end
    endtask

    task automatic queue_frame(input frame_kind_e kind);
        logic [WORD_W-1:0] t;
        int                header_slot;
        header_slot = (kind == FRAME_HEADER_INSIDE) ? $urandom_range(STORE_DEPTH - 1) : -1;
        word_backlog = {word_backlog, header_val};
        for (int k = 0; k < FRAME_WORDS - 2; k++)
        begin
            if (k == header_slot)
                word_backlog = {word_backlog, header_val};
            else
                word_backlog = {word_backlog,
                                sample_word(random_sample(), $urandom_range(9) != 0)};
        end
        if (kind == FRAME_BAD_TRAILER)
        begin
            do
                t = $urandom;
            while (t == trailer_val);
            word_backlog = {word_backlog, t};
        end
        else
        begin
            word_backlog = {word_backlog, trailer_val};
        end
    endtask

    // register write, issued between phases and once in the middle of a frame
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_HEADER:  header_val  = val[31:0];
            REG_TRAILER: trailer_val = val[31:0];
            REG_POLY:    poly_val    = val[7:0];
            REG_ORDER:   order_val   = val;
            REG_RADIUS:  radius_val  = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_settings(input logic [31:0] hdr, input logic [31:0] trl,
                                 input logic [7:0] poly, input logic [63:0] order,
                                 input logic [15:0] radius);
        write_reg(REG_HEADER, 64'(hdr));
        write_reg(REG_TRAILER, 64'(trl));
        write_reg(REG_POLY, 64'(poly));
        write_reg(REG_ORDER, order);
        write_reg(REG_RADIUS, 64'(radius));
    endtask

    // wait until every queued word is sent and every owed result is back, then let the block settle
    task automatic drain_results();
        while (word_backlog.size() != 0 || stream_ch.valid || pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input int frames, input int idle_pct, input int stall_pct);
        frame_kind_e kind;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int f = 0; f < frames; f++)
        begin
            queue_noise($urandom_range(3));
            // every phase drops at least one frame on its trailer
            if (f == 1)
                kind = FRAME_BAD_TRAILER;
            else
                case ($urandom_range(9))
                    0: kind = FRAME_BAD_TRAILER;
                    1: kind = FRAME_HEADER_INSIDE;
                    default: kind = FRAME_GOOD;
                endcase
            queue_frame(kind);
        end
        drain_results();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // output side: compare each result against the oldest owed one,
    // then feed any stream request taken at this edge into the predictor
    always @(posedge clk)
    begin
        channel_result_t want;
        channel_result_t got;
        word_taken = rst_n && stream_ch.valid && stream_ch.ready;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.channel = result_ch.channel;
            got.voltage = result_ch.voltage;
            got.crc_ok  = result_ch.crc_ok;
            got.last    = result_ch.last;
            results_checked++;
            if (pending_results.size() == 0)
            begin
                want = '0;
                note_fault("with nothing owed", want, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.channel !== want.channel || got.voltage !== want.voltage ||
                    got.crc_ok !== want.crc_ok || got.last !== want.last)
                    note_fault("differs", want, got);
            end
        end
        if (word_taken)
            absorb_stream_word(stream_ch.word);
    end

    // sender: a request stays up until taken, new ones start after random gaps
    always @(negedge clk)
    begin
        logic              next_valid;
        logic [WORD_W-1:0] next_word;
        next_valid = stream_ch.valid;
        next_word  = stream_ch.word;
        if (!rst_n)
        begin
            next_valid = 1'b0;
        end
        else if (!stream_ch.valid || word_taken)
        begin
            next_valid = 1'b0;
            if (word_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_valid = 1'b1;
                next_word  = word_backlog.pop_front();
            end
        end
        stream_ch.valid <= next_valid;
        stream_ch.word  <= next_word;
    end

    // receiver: random back-pressure on the result side
    always @(negedge clk)
    begin
        result_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timed out with %0d results owed", pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        // every input known from time zero
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        stream_ch.valid = 1'b0;
        stream_ch.word  = '0;
        result_ch.ready = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        word_taken      = 1'b0;
        cycle_count     = 0;
        requests_taken  = 0;
        frames_closed   = 0;
        frames_dropped  = 0;
        results_checked = 0;
        error_count     = 0;

        // register file and deframer after reset
        header_val  = HEADER_RST;
        trailer_val = TRAILER_RST;
        poly_val    = POLY_RST;
        order_val   = ORDER_RST;
        radius_val  = RADIUS_RST;
        collecting  = 1'b0;
        frame_pos   = 0;
        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            slot_sample[k] = '0;
            slot_ok[k]     = 1'b0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed frame under the reset settings (header and trailer both zero)
        word_backlog = {word_backlog, 32'h1234_5678};               // skipped while hunting
        word_backlog = {word_backlog, header_val};
        word_backlog = {word_backlog, sample_word(16'h7FFF, 1'b1)}; // most positive sample
        word_backlog = {word_backlog, sample_word(16'h8000, 1'b1)}; // most negative sample
        word_backlog = {word_backlog, sample_word(16'hFFFF, 1'b1)}; // -1, rounds down
        word_backlog = {word_backlog, header_val};                  // header value as data
        word_backlog = {word_backlog, sample_word(16'h1234, 1'b0)}; // damaged crc byte
        word_backlog = {word_backlog, sample_word(16'hABCD, 1'b0)};
        word_backlog = {word_backlog, 32'hFFFF_FFFF};
        word_backlog = {word_backlog, sample_word(16'h4000, 1'b1)};

        // settings change in the middle of a frame: slots already stored keep the
        // old crc verdict, scaling and channel order come from the new values
        drain_results();
        write_reg(REG_POLY, 64'h07);
        write_reg(REG_ORDER, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_RADIUS, 64'hFFFF);
        word_backlog = {word_backlog, sample_word(16'h8000, 1'b1)};
        word_backlog = {word_backlog, sample_word(16'h7FFF, 1'b1)};
        for (int k = 0; k < STORE_DEPTH - 10; k++)
            word_backlog = {word_backlog, sample_word(random_sample(), 1'b1)};
        word_backlog = {word_backlog, trailer_val};
        drain_results();

        // random frames, no idling on either side
        load_settings($urandom, $urandom, 8'($urandom), {$urandom, $urandom}, 16'($urandom));
        run_phase(4, 0, 0);

        // all-ones settings, sender mostly idle
        load_settings('1, '1, 8'hFF, '1, 16'hFFFF);
        run_phase(4, 73, 0);

        // all-zero settings, receiver mostly stalled
        load_settings('0, '0, 8'h00, '0, 16'h0000);
        run_phase(4, 0, 73);

        // random settings with the smallest nonzero radius, light idling both sides
        load_settings($urandom, $urandom, 8'($urandom), {$urandom, $urandom}, 16'd1);
        run_phase(4, 17, 17);

        $display("took %0d stream requests: %0d frames closed, %0d dropped on the trailer",
                 requests_taken, frames_closed, frames_dropped);
        $display("checked %0d channel results over six register settings, %0d mismatches",
                 results_checked, error_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
